[rtl/tqbrr_pkg.sv]
`default_nettype none
package tqbrr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES = 3;
  localparam int DATA_W = 32;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int BURST_W = 4;
  localparam int QSEL_W = 2;
  localparam logic [BURST_W-1:0] BURST_RESET = 4'd3;

  typedef enum logic [1:0] {
    ST_ENQ    = 2'd0,
    ST_DROP   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REQ_ENQ   = 1'b0,
    REQ_SERVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // one access to the shared queue store
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [QSEL_W-1:0] queue;
  } res_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [QSEL_W-1:0] next_q(input logic [QSEL_W-1:0] q);
    next_q = (q == QSEL_W'(NUM_QUEUES - 1)) ? '0 : q + QSEL_W'(1);
  endfunction

endpackage
`default_nettype wire

[rtl/tqbrr_ram.sv]
`default_nettype none
module tqbrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/tqbrr_sched.sv]
`default_nettype none
module tqbrr_sched (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                exec,
  input  wire logic                                req_type,
  input  wire logic [tqbrr_pkg::QSEL_W-1:0]        queue_sel,
  input  wire logic [tqbrr_pkg::DATA_W-1:0]        in_value,
  input  wire logic [tqbrr_pkg::BURST_W-1:0]       burst_len,
  output tqbrr_pkg::mem_req_t                      mem_req,
  output tqbrr_pkg::res_t                          res
);

  logic [tqbrr_pkg::PTR_W-1:0]   head [tqbrr_pkg::NUM_QUEUES];
  logic [tqbrr_pkg::PTR_W-1:0]   tail [tqbrr_pkg::NUM_QUEUES];
  logic [tqbrr_pkg::CNT_W-1:0]   fill [tqbrr_pkg::NUM_QUEUES];
  logic [tqbrr_pkg::QSEL_W-1:0]  cur_q;
  logic [tqbrr_pkg::BURST_W-1:0] turn;

  logic [tqbrr_pkg::BURST_W-1:0] limit;
  logic [tqbrr_pkg::QSEL_W-1:0]  c1;
  logic [tqbrr_pkg::QSEL_W-1:0]  c2;
  logic [tqbrr_pkg::QSEL_W-1:0]  serve_q;
  logic                          turn_over;
  logic                          found;
  logic                          sel_ok;
  logic                          enq_ok;
  logic                          is_serve;

  assign is_serve = (req_type == tqbrr_pkg::REQ_SERVE);
  assign limit = (burst_len == '0) ? tqbrr_pkg::BURST_W'(1) : burst_len;
  assign c1 = tqbrr_pkg::next_q(cur_q);
  assign c2 = tqbrr_pkg::next_q(c1);
  assign turn_over = (turn >= limit) || (fill[cur_q] == '0);
  assign sel_ok = (queue_sel != tqbrr_pkg::QSEL_W'(tqbrr_pkg::NUM_QUEUES));
  assign enq_ok = sel_ok && (fill[queue_sel] != tqbrr_pkg::CNT_W'(tqbrr_pkg::QUEUE_DEPTH));

  // turn passes in order current+1, current+2, then back to current itself
  always_comb begin
    found = 1'b1;
    serve_q = cur_q;
    if (turn_over) begin
      if (fill[c1] != '0) begin
        serve_q = c1;
      end else if (fill[c2] != '0) begin
        serve_q = c2;
      end else if (fill[cur_q] == '0) begin
        found = 1'b0;
      end
    end
  end

  always_comb begin
    mem_req.en = 1'b0;
    mem_req.we = 1'b0;
    mem_req.addr = '0;
    mem_req.wdata = in_value;
    res.status = tqbrr_pkg::ST_EMPTY;
    res.queue = cur_q;
    if (is_serve) begin
      res.queue = serve_q;
      if (found) begin
        res.status = tqbrr_pkg::ST_SERVED;
        mem_req.en = exec;
        mem_req.addr = tqbrr_pkg::ADDR_W'(serve_q) * tqbrr_pkg::ADDR_W'(tqbrr_pkg::QUEUE_DEPTH)
                       + tqbrr_pkg::ADDR_W'(head[serve_q]);
      end
    end else begin
      res.queue = queue_sel;
      if (enq_ok) begin
        res.status = tqbrr_pkg::ST_ENQ;
        mem_req.en = exec;
        mem_req.we = 1'b1;
        mem_req.addr = tqbrr_pkg::ADDR_W'(queue_sel) * tqbrr_pkg::ADDR_W'(tqbrr_pkg::QUEUE_DEPTH)
                       + tqbrr_pkg::ADDR_W'(tail[queue_sel]);
      end else begin
        res.status = tqbrr_pkg::ST_DROP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tqbrr_pkg::NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
      cur_q <= '0;
      turn <= '0;
    end else if (exec) begin
      if (is_serve) begin
        cur_q <= serve_q;
        if (!found) begin
          turn <= '0;
        end else if (turn_over) begin
          turn <= tqbrr_pkg::BURST_W'(1);
        end else begin
          turn <= turn + tqbrr_pkg::BURST_W'(1);
        end
      end
      for (int i = 0; i < tqbrr_pkg::NUM_QUEUES; i++) begin
        if (!is_serve && enq_ok && queue_sel == tqbrr_pkg::QSEL_W'(i)) begin
          tail[i] <= tqbrr_pkg::next_ptr(tail[i]);
          fill[i] <= fill[i] + tqbrr_pkg::CNT_W'(1);
        end
        if (is_serve && found && serve_q == tqbrr_pkg::QSEL_W'(i)) begin
          head[i] <= tqbrr_pkg::next_ptr(head[i]);
          fill[i] <= fill[i] - tqbrr_pkg::CNT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/three_queue_burst_round_robin_core.sv]
// Channel   Transfer when        Ports
// request   start && !busy       req_type, queue_sel, in_value
// result    done (one cycle)     status, out_value, out_queue
// config    cfg_wr_en            cfg_wr_data (burst length)
//
// Each item is captured, then gets one pointer update plus one access to the
// queue store; the result shows in the next cycle while the store read returns.
// A new request may be taken in the cycle the result is shown.
// rst is synchronous: pointers, counts, turn state clear; burst length goes to 3.
// The receiver cannot stall; results are never held.
`default_nettype none
module three_queue_burst_round_robin_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   req_type,
  input  wire logic [tqbrr_pkg::QSEL_W-1:0]           queue_sel,
  input  wire logic signed [tqbrr_pkg::DATA_W-1:0]    in_value,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [tqbrr_pkg::BURST_W-1:0]          cfg_wr_data,
  output logic                                        done,
  output logic [1:0]                                  status,
  output logic signed [tqbrr_pkg::DATA_W-1:0]         out_value,
  output logic [tqbrr_pkg::QSEL_W-1:0]                out_queue
);

  tqbrr_pkg::state_t             state;
  tqbrr_pkg::state_t             state_next;
  logic                          accept;
  logic                          exec;
  logic [tqbrr_pkg::BURST_W-1:0] burst_len;
  logic                          req_type_q;
  logic [tqbrr_pkg::QSEL_W-1:0]  queue_sel_q;
  logic [tqbrr_pkg::DATA_W-1:0]  in_value_q;
  tqbrr_pkg::mem_req_t           mem_req;
  tqbrr_pkg::res_t               res;
  tqbrr_pkg::res_t               res_q;
  logic [tqbrr_pkg::DATA_W-1:0]  rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tqbrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy = 1'b0;
    done = 1'b0;
    exec = 1'b0;
    case (state)
      tqbrr_pkg::S_IDLE: begin
        if (start) begin
          state_next = tqbrr_pkg::S_EXEC;
        end
      end
      tqbrr_pkg::S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
        state_next = tqbrr_pkg::S_RESP;
      end
      tqbrr_pkg::S_RESP: begin
        done = 1'b1;
        state_next = start ? tqbrr_pkg::S_EXEC : tqbrr_pkg::S_IDLE;
      end
      default: begin
        state_next = tqbrr_pkg::S_IDLE;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_len <= tqbrr_pkg::BURST_RESET;
    end else if (cfg_wr_en) begin
      burst_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_q <= req_type;
      queue_sel_q <= queue_sel;
      in_value_q <= in_value;
    end
    if (exec) begin
      res_q <= res;
    end
  end

  tqbrr_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .exec      (exec),
    .req_type  (req_type_q),
    .queue_sel (queue_sel_q),
    .in_value  (in_value_q),
    .burst_len (burst_len),
    .mem_req   (mem_req),
    .res       (res)
  );

  tqbrr_ram #(
    .WIDTH (tqbrr_pkg::DATA_W),
    .DEPTH (tqbrr_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  assign status = res_q.status;
  assign out_queue = res_q.queue;
  assign out_value = (res_q.status == tqbrr_pkg::ST_SERVED) ? rdata : '0;

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == tqbrr_pkg::S_EXEC))
    else $error("result without a preceding execute cycle");

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted request gave no result two cycles later");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != tqbrr_pkg::ST_SERVED) |-> (out_value == '0))
    else $error("nonzero value on a result that is not a serve");

  a_no_exec_write_on_serve: assert property (@(posedge clk) disable iff (rst)
    (exec && req_type_q == tqbrr_pkg::REQ_SERVE) |-> !mem_req.we || !mem_req.en)
    else $error("store written during a serve");

endmodule
`default_nettype wire
